/* src/stmetric_pkg.sv */
`default_nettype none

package stmetric_pkg;

    // number of spatial axes that take part (1 to 3)
    localparam int SPACE_DIMS = 3;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 24;
    localparam int PROD_W  = 2 * DATA_W;
    // time-time sum in Q24.72, with headroom
    localparam int TT_W    = 100;
    // lowered shift sum in Q16.48, with headroom
    localparam int TI_W    = PROD_W + 2;
    // accept to done, in cycles
    localparam int LATENCY = 7;

    localparam int NUM_AXES = 3;
    localparam int NUM_SYM  = 6;

    typedef logic signed [DATA_W-1:0] q824_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [TT_W-1:0]   tt_acc_t;
    typedef logic signed [TI_W-1:0]   ti_acc_t;

    // symmetric component order: xx, xy, xz, yy, yz, zz
    typedef enum logic [2:0] {
        SYM_XX = 3'd0,
        SYM_XY = 3'd1,
        SYM_XZ = 3'd2,
        SYM_YY = 3'd3,
        SYM_YZ = 3'd4,
        SYM_ZZ = 3'd5
    } sym_idx_t;

    // axes of each symmetric component, first axis never above the second
    localparam logic [1:0] PAIR_A [NUM_SYM] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PAIR_B [NUM_SYM] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    function automatic logic axis_on(input logic [1:0] axis);
        axis_on = (32'(axis) < SPACE_DIMS);
    endfunction

    function automatic sym_idx_t sym_idx(input logic [1:0] a, input logic [1:0] b);
        logic [1:0] lo;
        logic [1:0] hi;
        sym_idx_t   r;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        case ({lo, hi})
            4'b0000: r = SYM_XX;
            4'b0001: r = SYM_XY;
            4'b0010: r = SYM_XZ;
            4'b0101: r = SYM_YY;
            4'b0110: r = SYM_YZ;
            4'b1010: r = SYM_ZZ;
            default: r = SYM_XX;
        endcase
        sym_idx = r;
    endfunction

endpackage

`default_nettype wire

/* src/spacetime_metric_from_lapse_shift_core.sv */
// spacetime metric from lapse, shift and spatial metric, one grid point per item
//
// input channel: drive the lapse, the three shift components and the six
// spatial metric components and raise start; the item is taken at the clock
// edge where start is high and busy is low. busy stays low: the block is a
// fully pipelined datapath and takes one item every cycle.
// result channel: done is high for exactly one cycle with the ten metric
// components on the result ports, once the item has passed every stage. items
// come out in the order they went in. the receiver cannot hold results off
// and none is needed, since each stage moves on every cycle.
// the pipeline holds one stage of 32x32 products, one of the
// split 64x32 products, one to merge the partial products, three adder tree
// stages and one to round and saturate. throughput is one item per cycle.
// rst_n clears the stage valid bits at once; items in flight are dropped.
// arithmetic is signed Q8.24; the time-time and lowered shift sums are
// exact, rounded to nearest with ties up and saturated.
`default_nettype none

module spacetime_metric_from_lapse_shift_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic signed [31:0] lapse_value,
    input  wire logic signed [31:0] shift_x,
    input  wire logic signed [31:0] shift_y,
    input  wire logic signed [31:0] shift_z,
    input  wire logic signed [31:0] gamma_xx,
    input  wire logic signed [31:0] gamma_xy,
    input  wire logic signed [31:0] gamma_xz,
    input  wire logic signed [31:0] gamma_yy,
    input  wire logic signed [31:0] gamma_yz,
    input  wire logic signed [31:0] gamma_zz,
    output logic              done,
    output logic signed [31:0] metric_tt,
    output logic signed [31:0] metric_tx,
    output logic signed [31:0] metric_ty,
    output logic signed [31:0] metric_tz,
    output logic signed [31:0] metric_xx,
    output logic signed [31:0] metric_xy,
    output logic signed [31:0] metric_xz,
    output logic signed [31:0] metric_yy,
    output logic signed [31:0] metric_yz,
    output logic signed [31:0] metric_zz
);

    localparam int NA = stmetric_pkg::NUM_AXES;
    localparam int NS = stmetric_pkg::NUM_SYM;
    localparam int TT_W = stmetric_pkg::TT_W;
    localparam int TI_W = stmetric_pkg::TI_W;
    localparam int DW = stmetric_pkg::DATA_W;
    localparam int FW = stmetric_pkg::FRAC_W;
    localparam int NSTG = stmetric_pkg::LATENCY;
    localparam int TT_SHIFT = 2 * FW;
    localparam int TT_RND_W = TT_W - TT_SHIFT;
    localparam int TI_RND_W = TI_W - FW;

    // masked inputs
    stmetric_pkg::q824_t sh_m [NA];
    stmetric_pkg::q824_t gm [NS];

    // stage 1: 32x32 products
    logic signed [stmetric_pkg::PROD_W-1:0] lap2_s1_reg, lap2_s1_next;
    stmetric_pkg::prod_t shsh_s1_reg [NS];
    stmetric_pkg::prod_t shsh_s1_next [NS];
    stmetric_pkg::prod_t low_s1_reg [NA][NA];
    stmetric_pkg::prod_t low_s1_next [NA][NA];

    // stage 2: split products and first lowered shift adds
    stmetric_pkg::prod_t lap2_s2_reg;
    stmetric_pkg::prod_t hi_s2_reg [NS];
    stmetric_pkg::prod_t hi_s2_next [NS];
    logic signed [stmetric_pkg::PROD_W:0] lo_s2_reg [NS];
    logic signed [stmetric_pkg::PROD_W:0] lo_s2_next [NS];
    stmetric_pkg::ti_acc_t lowp_s2_reg [NA];
    stmetric_pkg::ti_acc_t lowp_s2_next [NA];
    stmetric_pkg::ti_acc_t lowc_s2_reg [NA];
    stmetric_pkg::ti_acc_t lowc_s2_next [NA];

    // stage 3: merged terms
    stmetric_pkg::tt_acc_t term_s3_reg [NS];
    stmetric_pkg::tt_acc_t term_s3_next [NS];
    stmetric_pkg::tt_acc_t lapt_s3_reg, lapt_s3_next;
    stmetric_pkg::ti_acc_t low_s3_reg [NA];
    stmetric_pkg::ti_acc_t low_s3_next [NA];

    // stages 4 to 6: adder tree
    stmetric_pkg::tt_acc_t part_s4_reg [4];
    stmetric_pkg::tt_acc_t part_s4_next [4];
    stmetric_pkg::tt_acc_t part_s5_reg [2];
    stmetric_pkg::tt_acc_t part_s5_next [2];
    stmetric_pkg::tt_acc_t sum_s6_reg, sum_s6_next;

    // lowered shift, rounded from stage 4 on
    stmetric_pkg::q824_t ti_pipe_reg [4:NSTG][NA];
    stmetric_pkg::q824_t ti_s4_next [NA];

    // spatial metric copies travel alongside
    stmetric_pkg::q824_t gam_pipe_reg [1:NSTG][NS];

    stmetric_pkg::q824_t tt_s7_next;
    stmetric_pkg::q824_t tt_s7_reg;

    logic [NSTG:1] vld_reg, vld_next;

    // ---------------------------------------------------------------- input masking
    always_comb
    begin
        sh_m[0] = stmetric_pkg::axis_on(2'd0) ? shift_x : '0;
        sh_m[1] = stmetric_pkg::axis_on(2'd1) ? shift_y : '0;
        sh_m[2] = stmetric_pkg::axis_on(2'd2) ? shift_z : '0;
        gm[stmetric_pkg::SYM_XX] = gamma_xx;
        gm[stmetric_pkg::SYM_XY] = gamma_xy;
        gm[stmetric_pkg::SYM_XZ] = gamma_xz;
        gm[stmetric_pkg::SYM_YY] = gamma_yy;
        gm[stmetric_pkg::SYM_YZ] = gamma_yz;
        gm[stmetric_pkg::SYM_ZZ] = gamma_zz;
        for (int k = 0; k < NS; k++)
        begin
            // the second axis is never below the first
            if (!stmetric_pkg::axis_on(stmetric_pkg::PAIR_B[k]))
            begin
                gm[k] = '0;
            end
        end
    end

    // ---------------------------------------------------------------- stage 1
    always_comb
    begin
        lap2_s1_next = lapse_value * lapse_value;
        for (int k = 0; k < NS; k++)
        begin
            shsh_s1_next[k] = sh_m[stmetric_pkg::PAIR_A[k]] * sh_m[stmetric_pkg::PAIR_B[k]];
        end
        // low_s1[i][m] = g_mi * b^m
        for (int i = 0; i < NA; i++)
        begin
            for (int m = 0; m < NA; m++)
            begin
                low_s1_next[i][m] = gm[stmetric_pkg::sym_idx(2'(m), 2'(i))] * sh_m[m];
            end
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_comb
    begin
        // b^a b^b times g_ab as signed high half and unsigned low half
        for (int k = 0; k < NS; k++)
        begin
            hi_s2_next[k] = $signed(shsh_s1_reg[k][2*DW-1:DW]) * gam_pipe_reg[1][k];
            lo_s2_next[k] = $signed({1'b0, shsh_s1_reg[k][DW-1:0]}) * gam_pipe_reg[1][k];
        end
        for (int i = 0; i < NA; i++)
        begin
            lowp_s2_next[i] = TI_W'(low_s1_reg[i][0]) + TI_W'(low_s1_reg[i][1]);
            // rounding half folded in here
            lowc_s2_next[i] = TI_W'(low_s1_reg[i][2]) + (TI_W'(1) <<< (FW - 1));
        end
    end

    // ---------------------------------------------------------------- stage 3
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            term_s3_next[k] = (TT_W'(hi_s2_reg[k]) <<< DW) + TT_W'(lo_s2_reg[k]);
            // off-diagonal terms count twice
            if (stmetric_pkg::PAIR_A[k] != stmetric_pkg::PAIR_B[k])
            begin
                term_s3_next[k] = term_s3_next[k] <<< 1;
            end
        end
        lapt_s3_next = (TT_W'(1) <<< (TT_SHIFT - 1)) - (TT_W'(lap2_s2_reg) <<< FW);
        for (int i = 0; i < NA; i++)
        begin
            low_s3_next[i] = lowp_s2_reg[i] + lowc_s2_reg[i];
        end
    end

    // ---------------------------------------------------------------- stage 4
    always_comb
    begin
        logic signed [TI_RND_W-1:0] ti_sh;
        logic [TI_RND_W-DW:0]       ti_top;
        part_s4_next[0] = term_s3_reg[0] + term_s3_reg[1];
        part_s4_next[1] = term_s3_reg[2] + term_s3_reg[3];
        part_s4_next[2] = term_s3_reg[4] + term_s3_reg[5];
        part_s4_next[3] = lapt_s3_reg;
        for (int i = 0; i < NA; i++)
        begin
            ti_sh  = TI_RND_W'(low_s3_reg[i] >>> FW);
            ti_top = ti_sh[TI_RND_W-1:DW-1];
            if ((&ti_top) || !(|ti_top))
            begin
                ti_s4_next[i] = ti_sh[DW-1:0];
            end
            else if (ti_sh[TI_RND_W-1])
            begin
                ti_s4_next[i] = {1'b1, {(DW-1){1'b0}}};
            end
            else
            begin
                ti_s4_next[i] = {1'b0, {(DW-1){1'b1}}};
            end
        end
    end

    // ---------------------------------------------------------------- stages 5 to 7
    always_comb
    begin
        logic signed [TT_RND_W-1:0] tt_sh;
        logic [TT_RND_W-DW:0]       tt_top;
        part_s5_next[0] = part_s4_reg[0] + part_s4_reg[1];
        part_s5_next[1] = part_s4_reg[2] + part_s4_reg[3];
        sum_s6_next     = part_s5_reg[0] + part_s5_reg[1];
        tt_sh  = TT_RND_W'(sum_s6_reg >>> TT_SHIFT);
        tt_top = tt_sh[TT_RND_W-1:DW-1];
        if ((&tt_top) || !(|tt_top))
        begin
            tt_s7_next = tt_sh[DW-1:0];
        end
        else if (tt_sh[TT_RND_W-1])
        begin
            tt_s7_next = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            tt_s7_next = {1'b0, {(DW-1){1'b1}}};
        end
    end

    // ---------------------------------------------------------------- valid bits
    always_comb
    begin
        vld_next = {vld_reg[NSTG-1:1], start & ~busy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        lap2_s1_reg  <= lap2_s1_next;
        shsh_s1_reg  <= shsh_s1_next;
        low_s1_reg   <= low_s1_next;
        gam_pipe_reg[1] <= gm;

        lap2_s2_reg  <= lap2_s1_reg;
        hi_s2_reg    <= hi_s2_next;
        lo_s2_reg    <= lo_s2_next;
        lowp_s2_reg  <= lowp_s2_next;
        lowc_s2_reg  <= lowc_s2_next;

        term_s3_reg  <= term_s3_next;
        lapt_s3_reg  <= lapt_s3_next;
        low_s3_reg   <= low_s3_next;

        part_s4_reg  <= part_s4_next;
        ti_pipe_reg[4] <= ti_s4_next;

        part_s5_reg  <= part_s5_next;
        sum_s6_reg   <= sum_s6_next;
        tt_s7_reg    <= tt_s7_next;

        for (int s = 2; s <= NSTG; s++)
        begin
            gam_pipe_reg[s] <= gam_pipe_reg[s-1];
        end
        for (int s = 5; s <= NSTG; s++)
        begin
            ti_pipe_reg[s] <= ti_pipe_reg[s-1];
        end
    end

    // ---------------------------------------------------------------- outputs
    assign busy      = 1'b0;
    assign done      = vld_reg[NSTG];
    assign metric_tt = tt_s7_reg;
    assign metric_tx = ti_pipe_reg[NSTG][0];
    assign metric_ty = ti_pipe_reg[NSTG][1];
    assign metric_tz = ti_pipe_reg[NSTG][2];
    assign metric_xx = gam_pipe_reg[NSTG][stmetric_pkg::SYM_XX];
    assign metric_xy = gam_pipe_reg[NSTG][stmetric_pkg::SYM_XY];
    assign metric_xz = gam_pipe_reg[NSTG][stmetric_pkg::SYM_XZ];
    assign metric_yy = gam_pipe_reg[NSTG][stmetric_pkg::SYM_YY];
    assign metric_yz = gam_pipe_reg[NSTG][stmetric_pkg::SYM_YZ];
    assign metric_zz = gam_pipe_reg[NSTG][stmetric_pkg::SYM_ZZ];

endmodule

`default_nettype wire

/* src/stmetric_checker.sv */
`default_nettype none

module stmetric_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic signed [31:0] gamma_xx,
    input wire logic signed [31:0] gamma_zz,
    input wire logic signed [31:0] metric_xx,
    input wire logic signed [31:0] metric_zz
);

    localparam int LAT = stmetric_pkg::LATENCY;

    // pipeline never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised by a pipeline that takes every cycle");

    // every accepted item comes out after the fixed latency
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item did not complete on time");

    // no result without an accepted item
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching item");

    // spatial copies line up with their own item
    a_copy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (metric_xx == $past(gamma_xx, LAT))
              && (metric_zz == (stmetric_pkg::axis_on(2'd2) ? $past(gamma_zz, LAT) : 32'sd0)))
        else $error("copied metric component out of step");

endmodule

bind spacetime_metric_from_lapse_shift_core stmetric_checker u_stmetric_checker (.*);

`default_nettype wire

/* tb/sv/spacetime_metric_from_lapse_shift_core_tb.sv */
`timescale 1ns / 1ps

module spacetime_metric_from_lapse_shift_core_tb;

    import stmetric_pkg::*;

    localparam q824_t ONE        = 32'sh0100_0000;
    localparam q824_t HALF       = 32'sh0080_0000;
    localparam q824_t MAX_Q      = 32'sh7FFF_FFFF;
    localparam q824_t MIN_Q      = 32'sh8000_0000;
    localparam int    IDLE_LIMIT = 2000;
    localparam int    NUM_RANDOM = 450;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        q824_t lapse_value;
        q824_t shift_x;
        q824_t shift_y;
        q824_t shift_z;
        q824_t gamma_xx;
        q824_t gamma_xy;
        q824_t gamma_xz;
        q824_t gamma_yy;
        q824_t gamma_yz;
        q824_t gamma_zz;
    } grid_point_t;

    typedef struct packed {
        q824_t metric_tt;
        q824_t metric_tx;
        q824_t metric_ty;
        q824_t metric_tz;
        q824_t metric_xx;
        q824_t metric_xy;
        q824_t metric_xz;
        q824_t metric_yy;
        q824_t metric_yz;
        q824_t metric_zz;
    } metric_t;

    typedef struct {
        grid_point_t pt;
        int          gap_after;
        bit          wait_drained;
    } queued_point_t;

    logic  clk;
    logic  rst_n       = 1'b0;
    logic  start       = 1'b0;
    q824_t lapse_value = '0;
    q824_t shift_x     = '0;
    q824_t shift_y     = '0;
    q824_t shift_z     = '0;
    q824_t gamma_xx    = '0;
    q824_t gamma_xy    = '0;
    q824_t gamma_xz    = '0;
    q824_t gamma_yy    = '0;
    q824_t gamma_yz    = '0;
    q824_t gamma_zz    = '0;

    logic  busy;
    logic  done;
    q824_t metric_tt, metric_tx, metric_ty, metric_tz;
    q824_t metric_xx, metric_xy, metric_xz, metric_yy, metric_yz, metric_zz;

    queued_point_t pending_points[$];
    metric_t       expected_metrics[$];
    grid_point_t   driven_point   = '0;
    int            gap_left       = 0;
    int            mismatch_count = 0;
    int            idle_cycles    = 0;

    spacetime_metric_from_lapse_shift_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .lapse_value (lapse_value),
        .shift_x     (shift_x),
        .shift_y     (shift_y),
        .shift_z     (shift_z),
        .gamma_xx    (gamma_xx),
        .gamma_xy    (gamma_xy),
        .gamma_xz    (gamma_xz),
        .gamma_yy    (gamma_yy),
        .gamma_yz    (gamma_yz),
        .gamma_zz    (gamma_zz),
        .done        (done),
        .metric_tt   (metric_tt),
        .metric_tx   (metric_tx),
        .metric_ty   (metric_ty),
        .metric_tz   (metric_tz),
        .metric_xx   (metric_xx),
        .metric_xy   (metric_xy),
        .metric_xz   (metric_xz),
        .metric_yy   (metric_yy),
        .metric_yz   (metric_yz),
        .metric_zz   (metric_zz)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic wide_t widen(input q824_t v);
        wide_t w;
        w = v;
        return w;
    endfunction

    // drop k fraction bits, nearest with ties toward plus infinity, then clamp
    function automatic q824_t round_sat(input wide_t v, input int k);
        wide_t r;
        wide_t hi_lim;
        wide_t lo_lim;
        hi_lim = 128'sd2147483647;
        lo_lim = -128'sd2147483648;
        r = (v + (wide_t'(1) <<< (k - 1))) >>> k;
        if (r > hi_lim)
            return MAX_Q;
        else if (r < lo_lim)
            return MIN_Q;
        return q824_t'(r[31:0]);
    endfunction

    function automatic metric_t predict_metric(input grid_point_t p);
        q824_t   sh[3];
        q824_t   g[3][3];
        q824_t   lowered[3];
        wide_t   tt_sum;
        wide_t   ti_sum;
        metric_t m;
        sh[0] = p.shift_x;
        sh[1] = p.shift_y;
        sh[2] = p.shift_z;
        g[0][0] = p.gamma_xx;
        g[0][1] = p.gamma_xy;
        g[1][0] = p.gamma_xy;
        g[0][2] = p.gamma_xz;
        g[2][0] = p.gamma_xz;
        g[1][1] = p.gamma_yy;
        g[1][2] = p.gamma_yz;
        g[2][1] = p.gamma_yz;
        g[2][2] = p.gamma_zz;
        // Q16.48 lapse square moved up to Q24.72
        tt_sum = -(widen(p.lapse_value) * widen(p.lapse_value)) <<< 24;
        // full double sum counts each off-diagonal term twice
        for (int a = 0; a < SPACE_DIMS; a++)
            for (int b = 0; b < SPACE_DIMS; b++)
                tt_sum += widen(sh[a]) * widen(sh[b]) * widen(g[a][b]);
        for (int a = 0; a < 3; a++)
        begin
            lowered[a] = '0;
            if (a < SPACE_DIMS)
            begin
                ti_sum = '0;
                for (int b = 0; b < SPACE_DIMS; b++)
                    ti_sum += widen(g[b][a]) * widen(sh[b]);
                lowered[a] = round_sat(ti_sum, 24);
            end
        end
        m = '0;
        m.metric_tt = round_sat(tt_sum, 48);
        m.metric_tx = lowered[0];
        m.metric_ty = lowered[1];
        m.metric_tz = lowered[2];
        m.metric_xx = p.gamma_xx;
        m.metric_xy = (SPACE_DIMS > 1) ? p.gamma_xy : '0;
        m.metric_xz = (SPACE_DIMS > 2) ? p.gamma_xz : '0;
        m.metric_yy = (SPACE_DIMS > 1) ? p.gamma_yy : '0;
        m.metric_yz = (SPACE_DIMS > 2) ? p.gamma_yz : '0;
        m.metric_zz = (SPACE_DIMS > 2) ? p.gamma_zz : '0;
        return m;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic q824_t rand_word();
        q824_t v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2:    v = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            3:
            begin
                case ($urandom_range(0, 6))
                    0: v = '0;
                    1: v = 32'sd1;
                    2: v = -32'sd1;
                    3: v = MAX_Q;
                    4: v = MIN_Q;
                    5: v = ONE;
                    default: v = -ONE;
                endcase
            end
            4:    v = ONE + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: v = -ONE + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
        return v;
    endfunction

    // lapse near one, modest shift, positive definite looking metric
    function automatic grid_point_t rand_physical_point();
        grid_point_t p;
        p.lapse_value = $urandom_range(32'h0080_0000, 32'h0200_0000);
        p.shift_x     = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        p.shift_y     = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        p.shift_z     = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        p.gamma_xx    = $urandom_range(32'h0080_0000, 32'h0200_0000);
        p.gamma_yy    = $urandom_range(32'h0080_0000, 32'h0200_0000);
        p.gamma_zz    = $urandom_range(32'h0080_0000, 32'h0200_0000);
        p.gamma_xy    = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        p.gamma_xz    = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        p.gamma_yz    = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        return p;
    endfunction

    function automatic grid_point_t rand_mixed_point();
        grid_point_t p;
        p.lapse_value = rand_word();
        p.shift_x     = rand_word();
        p.shift_y     = rand_word();
        p.shift_z     = rand_word();
        p.gamma_xx    = rand_word();
        p.gamma_xy    = rand_word();
        p.gamma_xz    = rand_word();
        p.gamma_yy    = rand_word();
        p.gamma_yz    = rand_word();
        p.gamma_zz    = rand_word();
        return p;
    endfunction

    task automatic queue_point(input grid_point_t p, input bit wait_drained);
        queued_point_t q;
        q.pt           = p;
        q.gap_after    = pick_gap();
        q.wait_drained = wait_drained;
        pending_points.push_back(q);
    endtask

    task automatic queue_fields(input q824_t lap, sx, sy, sz, gxx, gxy, gxz, gyy, gyz, gzz,
                                input bit wait_drained);
        grid_point_t p;
        p = '{lap, sx, sy, sz, gxx, gxy, gxz, gyy, gyz, gzz};
        queue_point(p, wait_drained);
    endtask

    task automatic check_field(input string field, input q824_t want, input q824_t got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d (%08h), got %0d (%08h)",
                   field, want, want, got, got);
            mismatch_count++;
        end
    endtask

    // driver: an item is taken at an edge with start high and busy low
    always @(posedge clk)
    begin
        queued_point_t nxt;
        bit            taken;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
                expected_metrics.push_back(predict_metric(driven_point));
            if (!start || taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_points.size() > 0 &&
                         !(pending_points[0].wait_drained && expected_metrics.size() > 0))
                begin
                    nxt          = pending_points.pop_front();
                    driven_point = nxt.pt;
                    gap_left     = nxt.gap_after;
                    lapse_value <= nxt.pt.lapse_value;
                    shift_x     <= nxt.pt.shift_x;
                    shift_y     <= nxt.pt.shift_y;
                    shift_z     <= nxt.pt.shift_z;
                    gamma_xx    <= nxt.pt.gamma_xx;
                    gamma_xy    <= nxt.pt.gamma_xy;
                    gamma_xz    <= nxt.pt.gamma_xz;
                    gamma_yy    <= nxt.pt.gamma_yy;
                    gamma_yz    <= nxt.pt.gamma_yz;
                    gamma_zz    <= nxt.pt.gamma_zz;
                    start       <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: each done pulse is one result item
    always @(posedge clk)
    begin
        metric_t want;
        if (rst_n && done)
        begin
            if (expected_metrics.size() == 0)
            begin
                $error("result item with no item outstanding");
                mismatch_count++;
            end
            else
            begin
                want = expected_metrics.pop_front();
                check_field("metric_tt", want.metric_tt, metric_tt);
                check_field("metric_tx", want.metric_tx, metric_tx);
                check_field("metric_ty", want.metric_ty, metric_ty);
                check_field("metric_tz", want.metric_tz, metric_tz);
                check_field("metric_xx", want.metric_xx, metric_xx);
                check_field("metric_xy", want.metric_xy, metric_xy);
                check_field("metric_xz", want.metric_xz, metric_xz);
                check_field("metric_yy", want.metric_yy, metric_yy);
                check_field("metric_yz", want.metric_yz, metric_yz);
                check_field("metric_zz", want.metric_zz, metric_zz);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        grid_point_t p;
        int          pick;

        queue_fields('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        // flat space, unit lapse
        queue_fields(ONE, '0, '0, '0, ONE, '0, '0, ONE, '0, ONE, 1'b0);
        queue_fields(MAX_Q, '0, '0, '0, ONE, '0, '0, ONE, '0, ONE, 1'b0);
        queue_fields(MIN_Q, ONE, ONE, ONE, ONE, '0, '0, ONE, '0, ONE, 1'b0);
        queue_fields('0, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, 1'b0);
        queue_fields('0, MIN_Q, MIN_Q, MIN_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, 1'b0);
        queue_fields(MAX_Q, MAX_Q, MAX_Q, MAX_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, 1'b0);
        queue_fields(MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, 1'b0);
        // lowered shift lands exactly on the range limits
        queue_fields('0, ONE, '0, '0, MAX_Q, '0, '0, '0, '0, '0, 1'b0);
        queue_fields('0, ONE, '0, '0, MIN_Q, '0, '0, '0, '0, '0, 1'b1);
        // ties in the lowered shift: +half rounds up, -half rounds to zero
        queue_fields('0, 32'sh0080_0000, '0, '0, 32'sd1, '0, '0, '0, '0, '0, 1'b0);
        queue_fields('0, -32'sh0080_0000, '0, '0, 32'sd1, '0, '0, '0, '0, '0, 1'b0);
        // ties in the time-time sum
        queue_fields('0, 32'sh0000_1000, '0, '0, 32'sh0080_0000, '0, '0, '0, '0, '0, 1'b0);
        queue_fields('0, 32'sh0000_1000, '0, '0, -32'sh0080_0000, '0, '0, '0, '0, '0, 1'b0);
        // lapse of one lsb: square is far below one lsb
        queue_fields(32'sd1, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        // off-diagonal terms, each counted twice in the time-time sum, plus one yy term
        queue_fields('0, ONE, ONE, ONE, '0, ONE, -HALF, 32'sh0040_0000, '0, '0, 1'b0);
        queue_fields(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                     32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                     32'shAAAA_AAAA, 32'sh5555_5555, 1'b1);
        queue_fields(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                     32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                     32'sh5555_5555, 32'shAAAA_AAAA, 1'b0);
        queue_fields(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                     -32'sd1, -32'sd1, 1'b0);
        queue_fields(HALF, HALF, -HALF, HALF, 2 * ONE, '0, '0, 2 * ONE, '0, 2 * ONE, 1'b0);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                p = rand_physical_point();
            else if (pick < 8)
                p = rand_mixed_point();
            else
                p = '{$urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom};
            queue_point(p, (n % 150) == 149);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_points.size() > 0 || start || expected_metrics.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        // every accepted item must have produced its result by now
        if (mismatch_count == 0 && expected_metrics.size() == 0 && !start)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
src/stmetric_pkg.sv
src/spacetime_metric_from_lapse_shift_core.sv
src/stmetric_checker.sv
tb/sv/spacetime_metric_from_lapse_shift_core_tb.sv
